### design/elf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_pkg
// Shared codes, widths and the saturating clamp of the 1D Euler step unit.
// ----------------------------------------------------------------------------
package elf_pkg;

  localparam int CELLS_DEF   = 1024;
  localparam int FRAC_DEF    = 24;
  localparam int DATA_W      = 32;
  localparam int IDX_FIELD_W = 10;
  localparam int IN_TDATA_W  = 208;
  localparam int OUT_TDATA_W = 160;
  localparam int GAMMA_W     = 31;

  localparam logic [GAMMA_W-1:0]     GAMMA_RESET = 31'd6710886;
  localparam logic [IDX_FIELD_W-1:0] LAST_RESET  = 10'd1023;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [1:0] CFG_GAMMA = 2'd0;
  localparam logic [1:0] CFG_LAST  = 2'd1;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } sres_t;

  function automatic sres_t clamp66(input logic signed [65:0] v);
    sres_t r;
    if (v > 66'(S32_MAX)) begin
      r.sat = 1'b1;
      r.val = S32_MAX;
    end else if (v < 66'(S32_MIN)) begin
      r.sat = 1'b1;
      r.val = S32_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### design/euler_1d_lax_friedrichs_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_1d_lax_friedrichs_step_unit
// Gas cell grid in five memories; load, read, or one Lax-Friedrichs step.
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata fields, in_tuser operation
// out_     out  out_tvalid/out_tready  out_tdata cell values, out_tuser status
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Load and unused operation answer from idle; a read first waits in S_RDW for
// the registered memory read. Step: cells 0..last_cell are swept; each is read
// and its fluxes formed, and from the third on the cell before gets its new
// state, bit-serial divider velocity (skipped at zero density) and pressure.
// Reset is synchronous; the memories hold no reset and need no clearing pass.
// An item is taken only when the output register is empty or being drained.
// ----------------------------------------------------------------------------
module euler_1d_lax_friedrichs_step_unit #(
  parameter int CELLS     = elf_pkg::CELLS_DEF,
  parameter int FRAC_BITS = elf_pkg::FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // cell_index, density, momentum, energy, velocity, pressure, step_ratio
  input  logic [elf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_density, out_momentum, out_energy, out_velocity, out_pressure
  output logic [elf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [elf_pkg::GAMMA_W-1:0]      cfg_data
);
  import elf_pkg::*;

  localparam int IDX_W    = $clog2(CELLS);
  localparam int LAST_MAX = CELLS - 1;
  localparam int QW       = DATA_W + FRAC_BITS;
  localparam int DCNT_W   = $clog2(QW);
  localparam logic [QW-1:0] Q_LIM = QW'(64'd2147483648);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDW   = 5'd1;
  localparam logic [4:0] S_SRD   = 5'd2;
  localparam logic [4:0] S_SWT   = 5'd3;
  localparam logic [4:0] S_F1    = 5'd4;
  localparam logic [4:0] S_F2    = 5'd5;
  localparam logic [4:0] S_F3    = 5'd6;
  localparam logic [4:0] S_U1    = 5'd7;
  localparam logic [4:0] S_U2    = 5'd8;
  localparam logic [4:0] S_U3    = 5'd9;
  localparam logic [4:0] S_DIV   = 5'd10;
  localparam logic [4:0] S_DEND  = 5'd11;
  localparam logic [4:0] S_P0    = 5'd12;
  localparam logic [4:0] S_P1    = 5'd13;
  localparam logic [4:0] S_P2    = 5'd14;
  localparam logic [4:0] S_P3    = 5'd15;
  localparam logic [4:0] S_SHIFT = 5'd16;

  // input fields
  logic [IDX_FIELD_W-1:0]   f_cell;
  logic signed [DATA_W-1:0] f_rho, f_mom, f_en, f_u, f_p, f_ratio;
  assign f_cell  = in_tdata[9:0];
  assign f_rho   = in_tdata[41:10];
  assign f_mom   = in_tdata[73:42];
  assign f_en    = in_tdata[105:74];
  assign f_u     = in_tdata[137:106];
  assign f_p     = in_tdata[169:138];
  assign f_ratio = in_tdata[201:170];

  logic [4:0]               state_r, state_nxt;
  logic [GAMMA_W-1:0]       gamma_r;
  logic [IDX_FIELD_W-1:0]   last_r;
  logic signed [DATA_W-1:0] ratio_r;
  logic [IDX_W-1:0]         cnt_r, last_eff;
  logic                     sat_r, zero_r, neg_r;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [1:0]               out_user_r;

  // memories and read registers
  logic signed [DATA_W-1:0] mem_rho [CELLS];
  logic signed [DATA_W-1:0] mem_mom [CELLS];
  logic signed [DATA_W-1:0] mem_en  [CELLS];
  logic signed [DATA_W-1:0] mem_u   [CELLS];
  logic signed [DATA_W-1:0] mem_p   [CELLS];
  logic signed [DATA_W-1:0] rd_rho, rd_mom, rd_en, rd_u, rd_p;
  logic                     rd_req, wr_req;
  logic [IDX_W-1:0]         rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_rho, wr_mom, wr_en, wr_u, wr_p;

  // neighbour window: a = cell i-2, b = cell i-1, current = read registers
  logic signed [DATA_W-1:0] oa_rho, oa_mom, oa_en, ob_rho, ob_mom, ob_en;
  logic signed [DATA_W-1:0] fa_rho, fa_mom, fa_en, fb_rho, fb_mom, fb_en;
  logic signed [DATA_W-1:0] fc_rho, fc_mom, fc_en;
  logic signed [DATA_W-1:0] nrho_r, nmom_r, nen_r, u_r;

  // shared multiplier
  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       prod_r, prod_sh;
  sres_t                    qs;

  // divider
  logic [32:0]              rem_r;
  logic [QW-1:0]            quo_r;
  logic [DATA_W-1:0]        dvs_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [32:0]              trial;
  logic                     tk;

  logic                     in_acc, idx_ok, out_free;
  logic                     out_set;
  logic [OUT_TDATA_W-1:0]   out_set_data;
  logic [1:0]               out_set_user;

  logic signed [DATA_W-1:0] lf_l, lf_r;
  logic signed [32:0]       half, diff;
  sres_t                    lf, fmom, ep, pr;
  logic signed [DATA_W-1:0] kin;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign idx_ok     = 32'(f_cell) < 32'(CELLS);
  assign last_eff   = (32'(last_r) > 32'(LAST_MAX)) ? IDX_W'(LAST_MAX) : IDX_W'(last_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign qs      = clamp66(prod_sh);
  assign trial   = {rem_r[31:0], quo_r[QW-1]};
  assign tk      = trial >= {1'b0, dvs_r};

  always_comb begin
    unique case (state_r)
      S_U2:    begin lf_l = oa_mom; lf_r = rd_mom; end
      S_U3:    begin lf_l = oa_en;  lf_r = rd_en;  end
      default: begin lf_l = oa_rho; lf_r = rd_rho; end
    endcase
    half = (33'(lf_l) + 33'(lf_r)) >>> 1;
    lf   = clamp66(66'(half) + prod_sh);
    fmom = clamp66(66'(qs.val) + 66'(rd_p));
    ep   = clamp66(66'(rd_en) + 66'(rd_p));
    kin  = qs.val >>> 1;
    diff = 33'(nen_r) - 33'(kin);
    pr   = qs;
  end

  always_comb begin
    unique case (state_r)
      S_SWT:   begin mul_a = 33'(rd_rho);  mul_b = 33'(rd_u);            end
      S_F1:    begin mul_a = 33'(qs.val);  mul_b = 33'(rd_u);            end
      S_F2:    begin mul_a = 33'(rd_u);    mul_b = 33'(ep.val);          end
      S_F3:    begin mul_a = 33'(ratio_r); mul_b = 33'(fa_rho) - 33'(fc_rho); end
      S_U1:    begin mul_a = 33'(ratio_r); mul_b = 33'(fa_mom) - 33'(fc_mom); end
      S_U2:    begin mul_a = 33'(ratio_r); mul_b = 33'(fa_en) - 33'(fc_en);   end
      S_P0:    begin mul_a = 33'(nrho_r);  mul_b = 33'(u_r);             end
      S_P1:    begin mul_a = 33'(qs.val);  mul_b = 33'(u_r);             end
      S_P2:    begin mul_a = $signed({2'b00, gamma_r}); mul_b = diff;    end
      default: begin mul_a = '0;           mul_b = '0;                   end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // memory ports
  always_comb begin
    rd_req  = (state_r == S_SRD) ||
              (in_acc && in_tuser == OP_READ && idx_ok);
    rd_addr = (state_r == S_SRD) ? cnt_r : IDX_W'(f_cell);
    wr_req  = (state_r == S_P3) || (in_acc && in_tuser == OP_LOAD && idx_ok);
    if (state_r == S_P3) begin
      wr_addr = cnt_r - IDX_W'(1);
      wr_rho  = nrho_r;
      wr_mom  = nmom_r;
      wr_en   = nen_r;
      wr_u    = u_r;
      wr_p    = pr.val;
    end else begin
      wr_addr = IDX_W'(f_cell);
      wr_rho  = f_rho;
      wr_mom  = f_mom;
      wr_en   = f_en;
      wr_u    = f_u;
      wr_p    = f_p;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req) begin
      mem_rho[wr_addr] <= wr_rho;
      mem_mom[wr_addr] <= wr_mom;
      mem_en[wr_addr]  <= wr_en;
      mem_u[wr_addr]   <= wr_u;
      mem_p[wr_addr]   <= wr_p;
    end
    if (rd_req) begin
      rd_rho <= mem_rho[rd_addr];
      rd_mom <= mem_mom[rd_addr];
      rd_en  <= mem_en[rd_addr];
      rd_u   <= mem_u[rd_addr];
      rd_p   <= mem_p[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    out_set      = 1'b0;
    out_set_data = '0;
    out_set_user = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            OP_LOAD: begin
              out_set      = 1'b1;
              out_set_user = idx_ok ? ST_OK : ST_RANGE;
            end
            OP_STEP: begin
              if (last_eff < IDX_W'(2)) out_set = 1'b1;
              else state_nxt = S_SRD;
            end
            OP_READ: begin
              if (idx_ok) begin
                state_nxt = S_RDW;
              end else begin
                out_set      = 1'b1;
                out_set_user = ST_RANGE;
              end
            end
            OP_NONE: out_set = 1'b1;
            default: out_set = 1'b1;
          endcase
        end
      end
      S_RDW: begin
        out_set      = 1'b1;
        out_set_data = {rd_p, rd_u, rd_en, rd_mom, rd_rho};
        state_nxt    = S_IDLE;
      end
      S_SRD: state_nxt = S_SWT;
      S_SWT: state_nxt = S_F1;
      S_F1:  state_nxt = S_F2;
      S_F2:  state_nxt = S_F3;
      S_F3:  state_nxt = (cnt_r >= IDX_W'(2)) ? S_U1 : S_SHIFT;
      S_U1:  state_nxt = S_U2;
      S_U2:  state_nxt = S_U3;
      S_U3:  state_nxt = (nrho_r == '0) ? S_P0 : S_DIV;
      S_DIV: state_nxt = (dcnt_r == DCNT_W'(QW - 1)) ? S_DEND : S_DIV;
      S_DEND: state_nxt = S_P0;
      S_P0:  state_nxt = S_P1;
      S_P1:  state_nxt = S_P2;
      S_P2:  state_nxt = S_P3;
      S_P3:  state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (cnt_r == last_eff) begin
          state_nxt    = S_IDLE;
          out_set      = 1'b1;
          out_set_user = zero_r ? ST_ZERO : (sat_r ? ST_SAT : ST_OK);
        end else begin
          state_nxt = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gamma_r     <= GAMMA_RESET;
      last_r      <= LAST_RESET;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      zero_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GAMMA) gamma_r <= cfg_data;
        if (cfg_index == CFG_LAST)  last_r  <= cfg_data[IDX_FIELD_W-1:0];
      end
      if (in_acc && in_tuser == OP_STEP) begin
        cnt_r  <= '0;
        sat_r  <= 1'b0;
        zero_r <= 1'b0;
      end
      unique case (state_r)
        S_F1:  sat_r <= sat_r | qs.sat;
        S_F2:  sat_r <= sat_r | qs.sat | fmom.sat | ep.sat;
        S_F3:  sat_r <= sat_r | qs.sat;
        S_U1, S_U2, S_U3: sat_r <= sat_r | lf.sat;
        S_DEND: sat_r <= sat_r | (quo_r >= Q_LIM && !(quo_r == Q_LIM && neg_r));
        S_P1, S_P2, S_P3: sat_r <= sat_r | qs.sat;
        S_SHIFT: if (cnt_r != last_eff) cnt_r <= cnt_r + IDX_W'(1);
        default: ;
      endcase
      if (state_r == S_U3 && nrho_r == '0) zero_r <= 1'b1;
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (out_set) begin
      out_data_r <= out_set_data;
      out_user_r <= out_set_user;
    end
    if (in_acc && in_tuser == OP_STEP) ratio_r <= f_ratio;
    unique case (state_r)
      S_F1: fc_rho <= qs.val;
      S_F2: fc_mom <= fmom.val;
      S_F3: fc_en  <= qs.val;
      S_U1: nrho_r <= lf.val;
      S_U2: nmom_r <= lf.val;
      S_U3: begin
        nen_r <= lf.val;
        neg_r <= nmom_r[DATA_W-1] ^ nrho_r[DATA_W-1];
        rem_r <= '0;
        dcnt_r <= '0;
        dvs_r <= nrho_r[DATA_W-1] ? DATA_W'(-33'(nrho_r)) : nrho_r;
        quo_r <= {(nmom_r[DATA_W-1] ? DATA_W'(-33'(nmom_r)) : DATA_W'(nmom_r)),
                  {FRAC_BITS{1'b0}}};
        if (nrho_r == '0) begin
          u_r <= (nmom_r == '0) ? '0 : (nmom_r[DATA_W-1] ? S32_MIN : S32_MAX);
        end
      end
      S_DIV: begin
        rem_r  <= tk ? (trial - {1'b0, dvs_r}) : trial;
        quo_r  <= {quo_r[QW-2:0], tk};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      S_DEND: begin
        if (quo_r > Q_LIM) u_r <= neg_r ? S32_MIN : S32_MAX;
        else if (neg_r) u_r <= DATA_W'(-(quo_r[DATA_W:0]));
        else if (quo_r == Q_LIM) u_r <= S32_MAX;
        else u_r <= quo_r[DATA_W-1:0];
      end
      S_SHIFT: begin
        oa_rho <= ob_rho; oa_mom <= ob_mom; oa_en <= ob_en;
        ob_rho <= rd_rho; ob_mom <= rd_mom; ob_en <= rd_en;
        fa_rho <= fb_rho; fa_mom <= fb_mom; fa_en <= fb_en;
        fb_rho <= fc_rho; fb_mom <= fc_mom; fb_en <= fc_en;
      end
      default: ;
    endcase
  end

endmodule

### design/elf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_chk
// Port-level checks for the Euler step unit, bound to the top level.
// ----------------------------------------------------------------------------
module elf_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [1:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [elf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);
  import elf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("item taken while result slot blocked");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_LOAD |=>
      out_tvalid && out_tdata == '0 && (out_tuser == ST_OK || out_tuser == ST_RANGE))
    else $error("load result wrong");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_NONE |=>
      out_tvalid && out_tdata == '0 && out_tuser == ST_OK)
    else $error("unused operation result wrong");

endmodule

bind euler_1d_lax_friedrichs_step_unit elf_chk u_elf_chk (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 1D Euler Lax-Friedrichs step unit against a predictor of the
// cell grid: loads, reads, unused operations and time steps with zero-density
// and saturation cases, under random idling on both sides and several register
// settings, each result compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import elf_pkg::*;

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct {
    q_t         rho;
    q_t         mom;
    q_t         en;
    q_t         vel;
    q_t         prs;
    logic [1:0] status;
  } cell_res_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [GAMMA_W-1:0]     cfg_data;

  euler_1d_lax_friedrichs_step_unit i_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [GAMMA_W-1:0]     gamma_m1;
  logic [IDX_FIELD_W-1:0] last_idx;
  q_t  rho_g[CELLS_DEF], mom_g[CELLS_DEF], en_g[CELLS_DEF], vel_g[CELLS_DEF], prs_g[CELLS_DEF];
  q_t  frho[CELLS_DEF], fmom[CELLS_DEF], fen[CELLS_DEF];
  q_t  nrho[CELLS_DEF], nmom[CELLS_DEF], nen[CELLS_DEF];
  bit  loaded[CELLS_DEF];
  bit  hit_sat, hit_zero;

  cell_res_t expected_cells[$];
  int        errors = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;

  function automatic q_t sat32(logic signed [95:0] v);
    if (v > 96'sh7fff_ffff) begin
      hit_sat = 1'b1;
      return S32_MAX;
    end
    if (v < -96'sh8000_0000) begin
      hit_sat = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic q_t fx_mul(q_t a, q_t b);
    logic signed [95:0] p;
    p = 96'(a) * 96'(b);
    return sat32(p >>> FRAC_DEF);
  endfunction

  function automatic q_t fx_div(q_t num, q_t den);
    longint unsigned n, d, q, r;
    bit neg, over;
    n = num < 0 ? longint'(-longint'(num)) : longint'(num);
    d = den < 0 ? longint'(-longint'(den)) : longint'(den);
    q = n / d;
    r = n % d;
    neg = (num < 0) != (den < 0);
    over = q > 64'h8000_0000;
    for (int i = 0; i < FRAC_DEF && !over; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
      if (q > 64'h8000_0000) over = 1'b1;
    end
    if (over) begin
      hit_sat = 1'b1;
      return neg ? S32_MIN : S32_MAX;
    end
    return sat32(neg ? -96'(q) : 96'(q));
  endfunction

  function automatic q_t lf_blend(q_t l, q_t r, q_t fl, q_t fr, q_t ratio);
    logic signed [95:0] half, corr;
    half = (96'(l) + 96'(r)) >>> 1;
    corr = (96'(ratio) * (96'(fl) - 96'(fr))) >>> FRAC_DEF;
    return sat32(half + corr);
  endfunction

  function automatic void advance_grid(q_t ratio);
    int  lc;
    q_t  ru, u, kin;
    logic signed [95:0] diff;
    lc = last_idx < CELLS_DEF - 1 ? last_idx : CELLS_DEF - 1;
    if (lc < 2) return;
    for (int i = 0; i <= lc; i++) begin
      ru = fx_mul(rho_g[i], vel_g[i]);
      frho[i] = ru;
      fmom[i] = sat32(96'(fx_mul(ru, vel_g[i])) + 96'(prs_g[i]));
      fen[i] = fx_mul(vel_g[i], sat32(96'(en_g[i]) + 96'(prs_g[i])));
    end
    for (int i = 1; i < lc; i++) begin
      nrho[i] = lf_blend(rho_g[i-1], rho_g[i+1], frho[i-1], frho[i+1], ratio);
      nmom[i] = lf_blend(mom_g[i-1], mom_g[i+1], fmom[i-1], fmom[i+1], ratio);
      nen[i]  = lf_blend(en_g[i-1], en_g[i+1], fen[i-1], fen[i+1], ratio);
    end
    for (int i = 1; i < lc; i++) begin
      rho_g[i] = nrho[i];
      mom_g[i] = nmom[i];
      en_g[i]  = nen[i];
      if (nrho[i] == 0) begin
        hit_zero = 1'b1;
        u = nmom[i] > 0 ? S32_MAX : (nmom[i] < 0 ? S32_MIN : 32'sd0);
      end else begin
        u = fx_div(nmom[i], nrho[i]);
      end
      vel_g[i] = u;
      kin = 32'(96'(fx_mul(fx_mul(nrho[i], u), u)) >>> 1);
      diff = 96'(nen[i]) - 96'(kin);
      prs_g[i] = sat32((96'($signed({1'b0, gamma_m1})) * diff) >>> FRAC_DEF);
    end
  endfunction

  function automatic cell_res_t predict_cell(logic [1:0] op, logic [9:0] idx,
                                             q_t d, q_t m, q_t e, q_t v, q_t p, q_t ratio);
    cell_res_t res;
    res = '{rho: 0, mom: 0, en: 0, vel: 0, prs: 0, status: ST_OK};
    case (op)
      OP_LOAD: begin
        rho_g[idx] = d;
        mom_g[idx] = m;
        en_g[idx] = e;
        vel_g[idx] = v;
        prs_g[idx] = p;
        loaded[idx] = 1'b1;
      end
      OP_STEP: begin
        hit_sat = 1'b0;
        hit_zero = 1'b0;
        advance_grid(ratio);
        res.status = hit_zero ? ST_ZERO : (hit_sat ? ST_SAT : ST_OK);
      end
      OP_READ: begin
        res.rho = rho_g[idx];
        res.mom = mom_g[idx];
        res.en = en_g[idx];
        res.vel = vel_g[idx];
        res.prs = prs_g[idx];
      end
      default: ;
    endcase
    return res;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    cell_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cells.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_tdata[31:0] !== want.rho) begin
          $error("out_density expected %h got %h", want.rho, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.mom) begin
          $error("out_momentum expected %h got %h", want.mom, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[95:64] !== want.en) begin
          $error("out_energy expected %h got %h", want.en, out_tdata[95:64]);
          errors++;
        end
        if (out_tdata[127:96] !== want.vel) begin
          $error("out_velocity expected %h got %h", want.vel, out_tdata[127:96]);
          errors++;
        end
        if (out_tdata[159:128] !== want.prs) begin
          $error("out_pressure expected %h got %h", want.prs, out_tdata[159:128]);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [9:0] idx, q_t d, q_t m, q_t e,
                           q_t v, q_t p, q_t ratio);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, ratio, p, v, e, m, d, idx};
    do @(posedge clk); while (!in_tready);
    expected_cells.push_back(predict_cell(op, idx, d, m, e, v, p, ratio));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [GAMMA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GAMMA) gamma_m1 = val;
    else if (idx == CFG_LAST) last_idx = val[IDX_FIELD_W-1:0];
  endtask

  task automatic load_cell(logic [9:0] idx, bit noise);
    q_t d, m, e, v, p;
    if (noise) begin
      d = $urandom; m = $urandom; e = $urandom; v = $urandom; p = $urandom;
    end else begin
      d = 32'h0080_0000 + $urandom_range(0, 32'h0200_0000);
      v = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      m = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      e = 32'h0100_0000 + $urandom_range(0, 32'h0300_0000);
      p = 32'h0030_0000 + $urandom_range(0, 32'h0180_0000);
    end
    send_item(OP_LOAD, idx, d, m, e, v, p, $urandom);
  endtask

  task automatic step_grid(q_t ratio);
    send_item(OP_STEP, 10'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
              ratio);
  endtask

  task automatic read_cell(logic [9:0] idx);
    send_item(OP_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic q_t small_ratio();
    return $signed($urandom_range(0, 32'h0033_3333)) - 32'sh0019_999a;
  endfunction

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_GAMMA, GAMMA_RESET);
    write_reg(CFG_LAST, 31'd15);
    send_item(OP_LOAD, 10'd0, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
    send_item(OP_LOAD, 10'd1, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    for (int i = 2; i < 16; i++) load_cell(10'(i), 1'b0);
    send_item(OP_LOAD, 10'd1023, 32'sh0100_0000, 0, 32'sh0100_0000, 0, 32'sh0010_0000, 0);
    read_cell(10'd0);
    read_cell(10'd1);
    read_cell(10'd1023);
    send_item(OP_NONE, 10'h3ff, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    step_grid(S32_MAX);
    read_cell(10'd1);
    drain();
    write_reg(CFG_LAST, 31'd3);
    for (int i = 0; i < 4; i++) send_item(OP_LOAD, 10'(i), 0, 0, 0, 0, 0, 0);
    step_grid(32'sh0010_0000);
    read_cell(10'd2);
    drain();
    write_reg(CFG_LAST, 31'd2);
    write_reg(CFG_GAMMA, {GAMMA_W{1'b1}});
    load_cell(10'd1, 1'b0);
    step_grid(S32_MIN);
    read_cell(10'd1);
    drain();
  endtask

  task automatic pick_settings();
    case ($urandom_range(3))
      0: write_reg(CFG_GAMMA, '0);
      1: write_reg(CFG_GAMMA, {GAMMA_W{1'b1}});
      2: write_reg(CFG_GAMMA, GAMMA_RESET);
      default: write_reg(CFG_GAMMA, GAMMA_W'($urandom));
    endcase
    write_reg(CFG_LAST, GAMMA_W'($urandom_range(2, 15)));
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int count);
    int k;
    logic [9:0] idx;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      if (n % (count / 2) == 0) begin
        drain();
        pick_settings();
      end
      k = $urandom_range(99);
      if (k < 45) begin
        idx = $urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 15));
        load_cell(idx, $urandom_range(99) < 15);
      end else if (k < 85) begin
        do idx = $urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 15));
        while (!loaded[idx]);
        read_cell(idx);
      end else if (k < 95) begin
        step_grid($urandom_range(9) == 0 ? q_t'($urandom) : small_ratio());
      end else begin
        send_item(OP_NONE, 10'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
      end
    end
    drain();
  endtask

  task automatic test_full_grid();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_GAMMA, GAMMA_RESET);
    write_reg(CFG_LAST, 31'd1023);
    for (int i = 0; i < CELLS_DEF; i++) load_cell(10'(i), 1'b0);
    step_grid(small_ratio());
    for (int i = 0; i < 16; i++) read_cell(10'($urandom));
    read_cell(10'd1022);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_NONE;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAMMA;
    cfg_data = '0;
    gamma_m1 = GAMMA_RESET;
    last_idx = LAST_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(27, 65, 200);
    test_random(65, 27, 200);
    test_full_grid();
    test_random(0, 0, 200);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
